@@ sv/slma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slma_pkg;

  // Operand width of the datapath.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = DATA_W / 2;

  // Operation kind.
  typedef enum logic {
    CMD_MAC   = 1'b0,
    CMD_LOGIC = 1'b1
  } cmd_t;

  // Logical operation codes.
  typedef enum logic [1:0] {
    LOP_AND  = 2'd0,
    LOP_ORR  = 2'd1,
    LOP_EOR  = 2'd2,
    LOP_ANDS = 2'd3
  } logic_op_t;

  // Shift kinds applied to the second operand.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // Load enables for the two multiplier stages.
  typedef struct packed {
    logic en_prod;
    logic en_sum;
  } mul_ctrl_t;

endpackage

`default_nettype wire

@@ sv/slma_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-stage low-half multiplier built from three 32x32 partial products.
module slma_mul #(
  parameter int unsigned DATA_W = slma_pkg::DATA_W
) (
  input  wire logic               clk,
  input  wire slma_pkg::mul_ctrl_t ctrl,
  input  wire logic [DATA_W-1:0]  a,
  input  wire logic [DATA_W-1:0]  b,
  output logic      [DATA_W-1:0]  prod
);

  localparam int unsigned HW = DATA_W / 2;

  logic [DATA_W-1:0] ll_full;
  logic [DATA_W-1:0] hl_full;
  logic [DATA_W-1:0] lh_full;
  logic [DATA_W-1:0] prod_ll;
  logic [HW-1:0]     prod_hl;
  logic [HW-1:0]     prod_lh;
  logic [HW-1:0]     cross_sum;

  // Partial products; only the low half of the cross terms reaches the result.
  always_comb begin
    ll_full = a[HW-1:0] * b[HW-1:0];
    hl_full = a[DATA_W-1:HW] * b[HW-1:0];
    lh_full = a[HW-1:0] * b[DATA_W-1:HW];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_prod) begin
      prod_ll <= ll_full;
      prod_hl <= hl_full[HW-1:0];
      prod_lh <= lh_full[HW-1:0];
    end
  end

  // Fold the cross terms into the upper half.
  assign cross_sum = prod_hl + prod_lh;

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      prod <= prod_ll + {cross_sum, {HW{1'b0}}};
    end
  end

endmodule

`default_nettype wire

@@ sv/shifted_logic_and_multiply_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Four register stages: an accepted instruction passes stages 1, 2, 3 and the output
// stage before out_valid rises. One instruction per cycle while the output is not
// stalled; the multiplier's 32x32 partial products and their fold fill stages 2 and 3.
// A stall on the output holds every stage that has no free slot behind it.
// Reset (rst, synchronous, active high) empties the pipeline; payload is not cleared.
module shifted_logic_and_multiply_alu #(
  parameter int unsigned DATA_W = slma_pkg::DATA_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              cmd,
  input  wire logic              wide,
  input  wire logic [1:0]        logic_op,
  input  wire logic              invert_second,
  input  wire logic [1:0]        shift_kind,
  input  wire logic [5:0]        shift_amount,
  input  wire logic              mul_subtract,
  input  wire logic [DATA_W-1:0] first_value,
  input  wire logic [DATA_W-1:0] second_value,
  input  wire logic [DATA_W-1:0] accum_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      result,
  output logic                   flags_written,
  output logic                   neg_flag,
  output logic                   zero_flag
);

  localparam int unsigned HW = DATA_W / 2;

  // Zero the upper half in 32-bit mode.
  function automatic logic [DATA_W-1:0] fit(input logic w, input logic [DATA_W-1:0] x);
    fit = w ? x : {{HW{1'b0}}, x[HW-1:0]};
  endfunction

  // Stage valid bits and ready chain.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // Stage 1: capture the instruction with operands cut to the selected width.
  slma_pkg::cmd_t        cmd1;
  logic                  wide1;
  slma_pkg::logic_op_t   op1;
  logic                  inv1;
  slma_pkg::shift_kind_t kind1;
  logic [5:0]            amt1;
  logic                  sub1;
  logic [DATA_W-1:0]     a1, b1, acc1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cmd1  <= slma_pkg::cmd_t'(cmd);
      wide1 <= wide;
      op1   <= slma_pkg::logic_op_t'(logic_op);
      inv1  <= invert_second;
      kind1 <= slma_pkg::shift_kind_t'(shift_kind);
      amt1  <= wide ? shift_amount : {1'b0, shift_amount[4:0]};
      sub1  <= mul_subtract;
      a1    <= fit(wide, first_value);
      b1    <= fit(wide, second_value);
      acc1  <= fit(wide, accum_value);
    end
  end

  // Barrel shift and optional inversion of the second operand.
  logic [DATA_W-1:0]   sh_raw;
  logic [2*DATA_W-1:0] rot_dbl;
  logic [DATA_W-1:0]   op2;

  always_comb begin
    rot_dbl = '0;
    case (kind1)
      slma_pkg::SH_LSL: sh_raw = b1 << amt1;
      slma_pkg::SH_LSR: sh_raw = b1 >> amt1;
      slma_pkg::SH_ASR: begin
        if (wide1) sh_raw = DATA_W'($signed(b1) >>> amt1);
        else sh_raw = DATA_W'($signed({{HW{b1[HW-1]}}, b1[HW-1:0]}) >>> amt1);
      end
      default: begin
        if (wide1) rot_dbl = {b1, b1} >> amt1;
        else rot_dbl = {{DATA_W{1'b0}}, b1[HW-1:0], b1[HW-1:0]} >> amt1;
        sh_raw = rot_dbl[DATA_W-1:0];
      end
    endcase
    op2 = fit(wide1, inv1 ? ~sh_raw : sh_raw);
  end

  // Stage 2: shifted operand; partial products sit in the multiplier.
  slma_pkg::cmd_t      cmd2;
  logic                wide2;
  slma_pkg::logic_op_t op2_code;
  logic                sub2;
  logic [DATA_W-1:0]   a2, sh2, acc2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cmd2     <= cmd1;
      wide2    <= wide1;
      op2_code <= op1;
      sub2     <= sub1;
      a2       <= a1;
      sh2      <= op2;
      acc2     <= acc1;
    end
  end

  slma_pkg::mul_ctrl_t mul_ctrl;
  logic [DATA_W-1:0]   prod3;

  assign mul_ctrl.en_prod = rdy2;
  assign mul_ctrl.en_sum  = rdy3;

  slma_mul #(
    .DATA_W(DATA_W)
  ) u_mul (
    .clk (clk),
    .ctrl(mul_ctrl),
    .a   (a1),
    .b   (b1),
    .prod(prod3)
  );

  // Logical combine of the first operand with the shifted one.
  logic [DATA_W-1:0] lres;

  always_comb begin
    case (op2_code)
      slma_pkg::LOP_ORR: lres = a2 | sh2;
      slma_pkg::LOP_EOR: lres = a2 ^ sh2;
      default:           lres = a2 & sh2;
    endcase
  end

  // Stage 3: logical result and carried accumulator.
  slma_pkg::cmd_t    cmd3;
  logic              wide3;
  logic              fset3;
  logic              sub3;
  logic [DATA_W-1:0] lres3, acc3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      cmd3  <= cmd2;
      wide3 <= wide2;
      fset3 <= (cmd2 == slma_pkg::CMD_LOGIC) && (op2_code == slma_pkg::LOP_ANDS);
      sub3  <= sub2;
      lres3 <= lres;
      acc3  <= acc2;
    end
  end

  // Accumulate and flag generation.
  logic [DATA_W-1:0] mac_res;
  logic [DATA_W-1:0] res_next;

  always_comb begin
    mac_res  = sub3 ? acc3 - prod3 : acc3 + prod3;
    res_next = (cmd3 == slma_pkg::CMD_LOGIC) ? lres3 : fit(wide3, mac_res);
  end

  // Stage 4: output register.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      result        <= res_next;
      flags_written <= fset3;
      neg_flag      <= fset3 && (wide3 ? lres3[DATA_W-1] : lres3[HW-1]);
      zero_flag     <= fset3 && (lres3 == '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/slma_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the result channel.
module slma_checker #(
  parameter int unsigned DATA_W = slma_pkg::DATA_W
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] result,
  input wire logic              flags_written,
  input wire logic              neg_flag,
  input wire logic              zero_flag
);

  // A held result must stay in place until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(flags_written))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid result after reset");

  // Flags stay low unless the flag-setting operation wrote them.
  a_noflags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !flags_written |-> !neg_flag && !zero_flag)
    else $error("flags set without flag write");

  // A zero flag implies a zero result with a clear sign.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_flag |-> result == '0 && !neg_flag)
    else $error("zero flag on nonzero result");

endmodule

bind shifted_logic_and_multiply_alu slma_checker #(
  .DATA_W(DATA_W)
) u_slma_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result       (result),
  .flags_written(flags_written),
  .neg_flag     (neg_flag),
  .zero_flag    (zero_flag)
);

`default_nettype wire
